FILE: rtl/rvx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared types and constants for the rv32i subset execute unit.
// ----------------------------------------------------------------------------
package rvx_pkg;

    localparam int unsigned XLEN       = 32;
    localparam int unsigned FUNC_W     = 4;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned SHAMT_W    = 5;
    localparam int unsigned S_TDATA_W  = 4 * XLEN;
    // alu value, taken, target packed, padded to whole bytes
    localparam int unsigned M_FIELDS_W = 2 * XLEN + 1;
    localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 4'd0,
        FN_SUB    = 4'd1,
        FN_ADDI   = 4'd2,
        FN_SLTI   = 4'd3,
        FN_SLTIU  = 4'd4,
        FN_XORI   = 4'd5,
        FN_ORI    = 4'd6,
        FN_ANDI   = 4'd7,
        FN_SLLI   = 4'd8,
        FN_SRLI   = 4'd9,
        FN_BEQ    = 4'd10,
        FN_BNE    = 4'd11,
        FN_STADDR = 4'd12,
        FN_LUI    = 4'd13,
        FN_JAL    = 4'd14,
        FN_UNSUP  = 4'd15
    } func_t;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_END         = 2'd2;

endpackage

FILE: rtl/rv32i_subset_execute_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_subset_execute_unit_top
// Execute stage for an rv32i subset: alu value, branch/jump decision and
// target, with fields not written by an operation held from earlier items.
// ----------------------------------------------------------------------------
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while m_tready does not stall the result, set
// by the single combinational alu/branch pass between the two registers.
// Reset (aresetn low, synchronous): both stages empty, held alu value,
// taken and target cleared to zero.
module rv32i_subset_execute_unit_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // first_operand, second_operand, imm_value, program_counter (low to high)
    input  logic [rvx_pkg::S_TDATA_W-1:0]  s_tdata,
    // func
    input  logic [rvx_pkg::FUNC_W-1:0]     s_tuser,
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // alu_value, taken, target, zero pad (low to high)
    output logic [rvx_pkg::M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [rvx_pkg::STATUS_W-1:0]   m_tuser
);

    localparam int unsigned XL = rvx_pkg::XLEN;

    // input stage
    logic                  in_valid_reg;
    rvx_pkg::func_t        in_func_reg;
    logic [XL-1:0]         in_a_reg;
    logic [XL-1:0]         in_b_reg;
    logic [XL-1:0]         in_imm_reg;
    logic [XL-1:0]         in_pc_reg;

    // result stage, also the held state
    logic                  out_valid_reg;
    logic [XL-1:0]         out_alu_reg;
    logic                  out_taken_reg;
    logic [XL-1:0]         out_target_reg;
    logic [rvx_pkg::STATUS_W-1:0] out_status_reg;

    logic [XL-1:0]         alu_next;
    logic                  taken_next;
    logic [XL-1:0]         target_next;
    logic [rvx_pkg::STATUS_W-1:0] status_next;
    logic [XL-1:0]         jal_target;
    logic                  advance;
    logic                  in_accept;

    // pipeline flow
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_func_reg <= rvx_pkg::func_t'(s_tuser);
            in_a_reg    <= s_tdata[XL-1:0];
            in_b_reg    <= s_tdata[2*XL-1:XL];
            in_imm_reg  <= s_tdata[3*XL-1:2*XL];
            in_pc_reg   <= s_tdata[4*XL-1:3*XL];
        end
    end

    // execute: start from held values, overwrite what the operation writes
    assign jal_target = in_pc_reg + in_imm_reg;

    always_comb begin
        alu_next    = out_alu_reg;
        taken_next  = out_taken_reg;
        target_next = out_target_reg;
        status_next = rvx_pkg::ST_OK;
        case (in_func_reg)
            rvx_pkg::FN_ADD:    alu_next = in_a_reg + in_b_reg;
            rvx_pkg::FN_SUB:    alu_next = in_a_reg - in_b_reg;
            rvx_pkg::FN_ADDI,
            rvx_pkg::FN_STADDR: alu_next = in_a_reg + in_imm_reg;
            rvx_pkg::FN_SLTI: begin
                alu_next = {{(XL-1){1'b0}}, ($signed(in_a_reg) < $signed(in_imm_reg))};
            end
            rvx_pkg::FN_SLTIU: begin
                alu_next = {{(XL-1){1'b0}}, (in_a_reg < in_imm_reg)};
            end
            rvx_pkg::FN_XORI:   alu_next = in_a_reg ^ in_imm_reg;
            rvx_pkg::FN_ORI:    alu_next = in_a_reg | in_imm_reg;
            rvx_pkg::FN_ANDI:   alu_next = in_a_reg & in_imm_reg;
            rvx_pkg::FN_SLLI:   alu_next = in_a_reg << in_imm_reg[rvx_pkg::SHAMT_W-1:0];
            rvx_pkg::FN_SRLI:   alu_next = in_a_reg >> in_imm_reg[rvx_pkg::SHAMT_W-1:0];
            rvx_pkg::FN_BEQ: begin
                taken_next  = (in_a_reg == in_b_reg);
                target_next = (in_a_reg == in_b_reg) ? in_imm_reg : '0;
            end
            rvx_pkg::FN_BNE: begin
                taken_next  = (in_a_reg != in_b_reg);
                target_next = (in_a_reg != in_b_reg) ? in_imm_reg : '0;
            end
            rvx_pkg::FN_LUI:    alu_next = in_imm_reg;
            rvx_pkg::FN_JAL: begin
                taken_next  = 1'b1;
                target_next = jal_target;
                if (jal_target == in_pc_reg) begin
                    status_next = rvx_pkg::ST_END;
                end
            end
            default:            status_next = rvx_pkg::ST_UNSUPPORTED;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            out_alu_reg    <= '0;
            out_taken_reg  <= 1'b0;
            out_target_reg <= '0;
        end else if (advance) begin
            out_valid_reg  <= 1'b1;
            out_alu_reg    <= alu_next;
            out_taken_reg  <= taken_next;
            out_target_reg <= target_next;
        end else if (m_tready) begin
            out_valid_reg  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_status_reg <= status_next;
        end
    end

    // outputs
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rvx_pkg::M_TDATA_W - rvx_pkg::M_FIELDS_W){1'b0}},
                       out_target_reg, out_taken_reg, out_alu_reg};
    assign m_tuser  = out_status_reg;

`ifndef ASSERT_OFF
    // an unsupported operation leaves the held state alone
    a_unsup_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_func_reg == rvx_pkg::FN_UNSUP |=>
            $stable(out_alu_reg) && $stable(out_taken_reg) && $stable(out_target_reg))
        else $error("unsupported operation changed held state");

    // end of program only comes from a taken jump
    a_end_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg == rvx_pkg::ST_END |-> out_taken_reg)
        else $error("end status without taken jump");

    // a not-taken branch clears the target
    a_branch_target: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_func_reg == rvx_pkg::FN_BEQ || in_func_reg == rvx_pkg::FN_BNE)
        |=> out_taken_reg || out_target_reg == '0)
        else $error("not-taken branch left a target");

    // input stage is only back-pressured while it holds an item
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without cause");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rv32i subset execute unit. Items go in over the
// slave stream with random gaps while the master side stalls at random. Each
// accepted item runs through a local execute model that keeps its own copy of
// the held alu value, taken flag and target. The expected result is queued
// and compared field by field with each result that comes out.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 5;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int HOLD_ITEMS    = 60;
    localparam int STEADY_ITEMS  = 300;
    localparam int unsigned XLEN = rvx_pkg::XLEN;

    // one result of the execute stage
    typedef struct packed {
        logic [XLEN-1:0]              alu;
        logic                         taken;
        logic [XLEN-1:0]              target;
        logic [rvx_pkg::STATUS_W-1:0] status;
    } exec_result_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [rvx_pkg::S_TDATA_W-1:0]   s_tdata  = '0;
    logic [rvx_pkg::FUNC_W-1:0]      s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [rvx_pkg::M_TDATA_W-1:0]   m_tdata;
    logic [rvx_pkg::STATUS_W-1:0]    m_tuser;

    // execute model state, as the block should hold it
    logic [XLEN-1:0]        held_alu    = '0;
    logic                   held_taken  = 1'b0;
    logic [XLEN-1:0]        held_target = '0;

    exec_result_t           pending_results[$];
    int                     failures     = 0;
    bit                     src_idle_en  = 1'b1;
    bit                     dst_idle_en  = 1'b1;
    int                     hold_request = 0;

    rv32i_subset_execute_unit_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // execute model: updates the held fields and returns the full result
    function automatic exec_result_t execute_item(input rvx_pkg::func_t f,
                                                  input logic [XLEN-1:0] a,
                                                  input logic [XLEN-1:0] b,
                                                  input logic [XLEN-1:0] imm,
                                                  input logic [XLEN-1:0] pc);
        exec_result_t r;
        logic [rvx_pkg::STATUS_W-1:0] st;
        st = rvx_pkg::ST_OK;
        case (f)
            rvx_pkg::FN_ADD:    held_alu = a + b;
            rvx_pkg::FN_SUB:    held_alu = a - b;
            rvx_pkg::FN_ADDI:   held_alu = a + imm;
            rvx_pkg::FN_SLTI:   held_alu = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
            rvx_pkg::FN_SLTIU:  held_alu = (a < imm) ? 32'd1 : 32'd0;
            rvx_pkg::FN_XORI:   held_alu = a ^ imm;
            rvx_pkg::FN_ORI:    held_alu = a | imm;
            rvx_pkg::FN_ANDI:   held_alu = a & imm;
            rvx_pkg::FN_SLLI:   held_alu = a << imm[rvx_pkg::SHAMT_W-1:0];
            rvx_pkg::FN_SRLI:   held_alu = a >> imm[rvx_pkg::SHAMT_W-1:0];
            rvx_pkg::FN_BEQ: begin
                held_taken  = (a == b);
                held_target = held_taken ? imm : '0;
            end
            rvx_pkg::FN_BNE: begin
                held_taken  = (a != b);
                held_target = held_taken ? imm : '0;
            end
            rvx_pkg::FN_STADDR: held_alu = a + imm;
            rvx_pkg::FN_LUI:    held_alu = imm;
            rvx_pkg::FN_JAL: begin
                held_taken  = 1'b1;
                held_target = pc + imm;
                // a jump to itself marks the end of the program
                if (held_target == pc) begin
                    st = rvx_pkg::ST_END;
                end
            end
            default:   st = rvx_pkg::ST_UNSUPPORTED;
        endcase
        r.alu    = held_alu;
        r.taken  = held_taken;
        r.target = held_target;
        r.status = st;
        return r;
    endfunction

    // operand values biased toward the edges
    function automatic logic [XLEN-1:0] pick_word();
        logic [XLEN-1:0] w;
        case ($urandom_range(0, 7))
            0:       w = '0;
            1:       w = '1;
            2:       w = 32'h8000_0000;
            3:       w = 32'h7fff_ffff;
            4:       w = $urandom_range(0, 40);
            default: w = $urandom;
        endcase
        return w;
    endfunction

    // drive one item, wait for its handshake, queue its expected result
    task automatic send_item(input rvx_pkg::func_t f, input logic [XLEN-1:0] a,
                             input logic [XLEN-1:0] b, input logic [XLEN-1:0] imm,
                             input logic [XLEN-1:0] pc);
        int gap;
        @(negedge aclk);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pc, imm, b, a};
        s_tuser  <= f;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(execute_item(f, a, b, imm, pc));
    endtask

    // drop valid, end on a rising edge
    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_random_item();
        logic [rvx_pkg::FUNC_W-1:0] code;
        rvx_pkg::func_t             f;
        logic [XLEN-1:0]            a;
        logic [XLEN-1:0]            b;
        logic [XLEN-1:0]            imm;
        code = rvx_pkg::FUNC_W'($urandom_range(0, 15));
        f    = rvx_pkg::func_t'(code);
        a    = pick_word();
        // equal operands often enough to take branches both ways
        b    = ($urandom_range(0, 3) == 0) ? a : pick_word();
        imm  = (f == rvx_pkg::FN_JAL && $urandom_range(0, 3) == 0) ? '0 : pick_word();
        send_item(f, a, b, imm, pick_word());
    endtask

    // receiver: random stall bursts, plus a long hold when requested
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                m_tready <= 1'b0;
                hold_request--;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else if (dst_idle_en && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 14) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        exec_result_t want;
        exec_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.alu    = m_tdata[XLEN-1:0];
            got.taken  = m_tdata[XLEN];
            got.target = m_tdata[2*XLEN:XLEN+1];
            got.status = m_tuser;
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("unexpected result: alu %h taken %b target %h status %0d",
                             got.alu, got.taken, got.target, got.status);
                end
            end else begin
                want = pending_results.pop_front();
                if (got.alu != want.alu || got.taken != want.taken ||
                    got.target != want.target || got.status != want.status) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("mismatch: expected alu %h taken %b target %h status %0d",
                                 want.alu, want.taken, want.target, want.status);
                        $display("          actual   alu %h taken %b target %h status %0d",
                                 got.alu, got.taken, got.target, got.status);
                    end
                end
            end
        end
    end

    // extremes, every operation, reset values, held fields, self jump
    task automatic test_directed();
        send_item(rvx_pkg::FN_BNE,    32'd5,         32'd5,         32'h0000_0040,
                  32'h0000_0100);
        send_item(rvx_pkg::FN_UNSUP,  32'hdead_beef, 32'h1234_5678, 32'h0000_0008,
                  32'h0000_0104);
        send_item(rvx_pkg::FN_ADD,    32'hffff_ffff, 32'h0000_0001, 32'h0, 32'h0);
        send_item(rvx_pkg::FN_ADD,    32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0);
        send_item(rvx_pkg::FN_SUB,    32'h0,         32'h0000_0001, 32'h0, 32'h0);
        send_item(rvx_pkg::FN_ADDI,   32'h0,         32'h0,         32'hffff_ffff, 32'h0);
        send_item(rvx_pkg::FN_SLTI,   32'h8000_0000, 32'h0,         32'h7fff_ffff, 32'h0);
        send_item(rvx_pkg::FN_SLTI,   32'h7fff_ffff, 32'h0,         32'h8000_0000, 32'h0);
        send_item(rvx_pkg::FN_SLTIU,  32'h8000_0000, 32'h0,         32'h7fff_ffff, 32'h0);
        send_item(rvx_pkg::FN_SLTIU,  32'h0,         32'h0,         32'hffff_ffff, 32'h0);
        send_item(rvx_pkg::FN_XORI,   32'hffff_ffff, 32'h0,         32'h5a5a_5a5a, 32'h0);
        send_item(rvx_pkg::FN_ORI,    32'h0,         32'h0,         32'hffff_ffff, 32'h0);
        send_item(rvx_pkg::FN_ANDI,   32'hffff_ffff, 32'hffff_ffff, 32'h0,         32'h0);
        send_item(rvx_pkg::FN_SLLI,   32'h0000_0001, 32'h0,         32'h0000_001f, 32'h0);
        // only the low five immediate bits set the shift amount
        send_item(rvx_pkg::FN_SLLI,   32'hffff_ffff, 32'h0,         32'hffff_ffe1, 32'h0);
        send_item(rvx_pkg::FN_SRLI,   32'h8000_0000, 32'h0,         32'h0000_001f, 32'h0);
        send_item(rvx_pkg::FN_SRLI,   32'hffff_ffff, 32'h0,         32'h0000_0020, 32'h0);
        send_item(rvx_pkg::FN_BEQ,    32'hffff_ffff, 32'hffff_ffff, 32'hffff_f000,
                  32'h0000_0200);
        send_item(rvx_pkg::FN_UNSUP,  32'h0,         32'h0,         32'h0,         32'h0);
        send_item(rvx_pkg::FN_BEQ,    32'h0000_0001, 32'h0000_0002, 32'h0000_0010, 32'h0);
        send_item(rvx_pkg::FN_BNE,    32'h0,         32'hffff_ffff, 32'h8000_0000, 32'h0);
        send_item(rvx_pkg::FN_STADDR, 32'h0000_1000, 32'h0,         32'hffff_fffc, 32'h0);
        send_item(rvx_pkg::FN_LUI,    32'h0,         32'h0,         32'hffff_f000, 32'h0);
        // jump target wraps past the top of the address space
        send_item(rvx_pkg::FN_JAL,    32'h0,         32'h0,         32'h0000_0020,
                  32'hffff_fff0);
        send_item(rvx_pkg::FN_JAL,    32'h0,         32'h0,         32'h0,
                  32'h0000_1234);
        send_item(rvx_pkg::FN_JAL,    32'hffff_ffff, 32'hffff_ffff, 32'h0,         32'h0);
        stop_sending();
    endtask

    // random operations with idling switched on and off by stretches
    task automatic test_random_mix();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0) begin
                src_idle_en = ($urandom_range(0, 3) != 0);
                dst_idle_en = ($urandom_range(0, 3) != 0);
            end
            send_random_item();
        end
        stop_sending();
    endtask

    // receiver holds off while items keep coming, so the input stalls
    task automatic test_receiver_hold();
        src_idle_en  = 1'b0;
        dst_idle_en  = 1'b1;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < HOLD_ITEMS; i++) begin
            send_random_item();
        end
        stop_sending();
    endtask

    // back to back items, no idling on either side
    task automatic test_steady_stream();
        src_idle_en = 1'b0;
        dst_idle_en = 1'b0;
        for (int i = 0; i < STEADY_ITEMS; i++) begin
            send_random_item();
        end
        stop_sending();
    endtask

    // sequence
    initial begin
        int waited;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_mix();
        test_receiver_hold();
        test_steady_stream();

        // drain the remaining results
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            failures++;
            $display("%0d expected results never arrived", pending_results.size());
        end

        if (failures == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/rvx_pkg.sv
rtl/rv32i_subset_execute_unit_top.sv
tb/testbench.sv
